>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define TMVA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// The condition must never be true outside reset.
`define TMVA_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> sv/tmva_pkg.sv
// ----------------------------------------------------------------------------
// tmva_pkg
// Types and fixed constants of the mixed Voronoi corner area pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tmva_pkg;

  // Limb width of the partial products inside the pipelined multiplier.
  localparam int MUL_LIMB_W = 32;
  // Register stages of one pipelined multiplier.
  localparam int MUL_LAT = 3;

  // Result format is unsigned Q16.16.
  localparam int AREA_W = 32;
  // Doubled area in units of 2^-32 to a quarter and an eighth in units of 2^-16.
  localparam int QUARTER_SHIFT = 18;
  localparam int EIGHTH_SHIFT = 19;
  // The Voronoi divisor is the doubled area shifted by this amount.
  localparam int DIV_SHIFT = 19;
  localparam int DIV_SAT_SHIFT = DIV_SHIFT + AREA_W;

  // Per-item results that are settled before the division runs.
  typedef struct packed {
    logic [2:0][AREA_W-1:0] fv;  // fixed area of each corner
    logic [2:0]             fs;  // saturation of each corner
    logic [2:0]             uq;  // corner takes the division quotient
    logic                   dg;  // degenerate triangle
  } tmva_side_t;

endpackage

`default_nettype wire

>>> sv/tmva_mul.sv
// ----------------------------------------------------------------------------
// tmva_mul
// Unsigned pipelined multiplier: limb products, row sums, final sum.
// ----------------------------------------------------------------------------
`default_nettype none

module tmva_mul
  import tmva_pkg::*;
#(
  parameter int W = 32
) (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire logic [W-1:0]   a_i,
  input  wire logic [W-1:0]   b_i,
  output logic      [2*W-1:0] p_o
);

  localparam int L  = (W + MUL_LIMB_W - 1) / MUL_LIMB_W;
  localparam int PW = 2 * L * MUL_LIMB_W;

  logic [L*MUL_LIMB_W-1:0] a_pad;
  logic [L*MUL_LIMB_W-1:0] b_pad;
  logic [2*MUL_LIMB_W-1:0] pp_q [L][L];
  logic [PW-1:0]           row_d [L];
  logic [PW-1:0]           row_q [L];
  logic [PW-1:0]           sum_d;
  logic [2*W-1:0]          p_q;

  assign a_pad = (L*MUL_LIMB_W)'(a_i);
  assign b_pad = (L*MUL_LIMB_W)'(b_i);

  always_comb begin
    for (int i = 0; i < L; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < L; j++) begin
        row_d[i] = row_d[i] + (PW'(pp_q[i][j]) << (j * MUL_LIMB_W));
      end
    end
    sum_d = '0;
    for (int i = 0; i < L; i++) begin
      sum_d = sum_d + (row_q[i] << (i * MUL_LIMB_W));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < L; i++) begin
        for (int j = 0; j < L; j++) begin
          pp_q[i][j] <= a_pad[i*MUL_LIMB_W +: MUL_LIMB_W] * b_pad[j*MUL_LIMB_W +: MUL_LIMB_W];
        end
        row_q[i] <= row_d[i];
      end
      p_q <= sum_d[2*W-1:0];
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

>>> sv/triangle_mixed_voronoi_area_top.sv
// ----------------------------------------------------------------------------
// triangle_mixed_voronoi_area_top
// Mixed Voronoi area of each corner of a 3D triangle, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one triangle per clock cycle while s_axis_tready is high
// and returns its three corner areas in order, one result per triangle. The
// depth is set by the square root of the squared cross product norm, which
// resolves one root bit per stage, followed by the three restoring dividers,
// which resolve one quotient bit per stage. A stall on the result side
// freezes the whole pipeline; an output register plus one skid register keep
// s_axis_tready high while a finished result waits, and tready drops only
// while the skid register is occupied.
`default_nettype none

module triangle_mixed_voronoi_area_top
  import tmva_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, COORD_BITS each, zero padded
  input  wire logic [((9*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // area_corner_a, area_corner_b, area_corner_c
  output logic [3*AREA_W-1:0]        m_axis_tdata,
  // degenerate, saturated
  output logic [1:0]                 m_axis_tuser
);

  localparam int C   = COORD_BITS;
  localparam int EW  = C + 1;          // signed edge component
  localparam int SPW = 2 * C + 1;      // signed edge product
  localparam int XW  = 2 * C + 2;      // signed cross component
  localparam int XMW = 2 * C + 1;      // cross magnitude
  localparam int DW  = 2 * C + 3;      // signed corner dot product
  localparam int QW  = 2 * C + 2;      // squared edge length, dot magnitude
  localparam int SW  = 4 * C + 4;      // squared cross norm
  localparam int TW  = 2 * C + 2;      // doubled area
  localparam int NW  = 4 * C + 5;      // Voronoi numerator
  localparam int RW  = (NW > TW + DIV_SAT_SHIFT) ? NW : TW + DIV_SAT_SHIFT;
  localparam int NP  = 24;             // edge products
  localparam int DOT0 = 6;
  localparam int SQ0  = 15;
  localparam int NST = 2 * MUL_LAT + 6 + TW + 1 + AREA_W;

  logic adv;
  logic push;
  logic take;
  logic [NST:1] v_q;

  // --------------------------------------------------------------------------
  // Stage 1: edge vectors. Stage 2: magnitudes and signs.
  // --------------------------------------------------------------------------
  logic signed [C-1:0]  crd [3][3];
  logic signed [EW-1:0] e_q [3][3];
  logic [C-1:0]         em_q [3][3];
  logic                 es_q [3][3];

  for (genvar gi = 0; gi < 3; gi++) begin : g_edge
    for (genvar gk = 0; gk < 3; gk++) begin : g_axis
      localparam int NI = (gi + 1) % 3;
      assign crd[gi][gk] = s_axis_tdata[(3*gi+gk)*C +: C];
      always_ff @(posedge clk_i) begin
        if (adv) begin
          e_q[gi][gk]  <= EW'(crd[NI][gk]) - EW'(crd[gi][gk]);
          em_q[gi][gk] <= e_q[gi][gk][EW-1] ? C'(-e_q[gi][gk]) : C'(e_q[gi][gk]);
          es_q[gi][gk] <= e_q[gi][gk][EW-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 3 to 5: all edge products on magnitudes, signs travel alongside.
  // The dot products enter negated, so the sums below give d directly.
  // --------------------------------------------------------------------------
  logic [C-1:0]   ma [NP];
  logic [C-1:0]   mb [NP];
  logic [NP-1:0]  psg;
  logic [2*C-1:0] pm [NP];
  logic [NP-1:0]  sgd_q [MUL_LAT];

  for (genvar gc = 0; gc < 3; gc++) begin : g_crs
    localparam int A = (gc + 1) % 3;
    localparam int B = (gc + 2) % 3;
    assign ma[2*gc]    = em_q[0][A];
    assign mb[2*gc]    = em_q[1][B];
    assign psg[2*gc]   = es_q[0][A] ^ es_q[1][B];
    assign ma[2*gc+1]  = em_q[0][B];
    assign mb[2*gc+1]  = em_q[1][A];
    assign psg[2*gc+1] = es_q[0][B] ^ es_q[1][A];
  end

  for (genvar gi = 0; gi < 3; gi++) begin : g_dot
    localparam int M = (gi + 2) % 3;
    for (genvar gk = 0; gk < 3; gk++) begin : g_axis
      assign ma[DOT0+3*gi+gk]  = em_q[gi][gk];
      assign mb[DOT0+3*gi+gk]  = em_q[M][gk];
      assign psg[DOT0+3*gi+gk] = ~(es_q[gi][gk] ^ es_q[M][gk]);
      assign ma[SQ0+3*gi+gk]   = em_q[gi][gk];
      assign mb[SQ0+3*gi+gk]   = em_q[gi][gk];
      assign psg[SQ0+3*gi+gk]  = 1'b0;
    end
  end

  for (genvar gn = 0; gn < NP; gn++) begin : g_emul
    tmva_mul #(.W(C)) u_mul (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (ma[gn]),
      .b_i   (mb[gn]),
      .p_o   (pm[gn])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sgd_q[0] <= psg;
      for (int j = 1; j < MUL_LAT; j++) begin
        sgd_q[j] <= sgd_q[j-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: signed products. Stage 7: cross, d and squared lengths.
  // Stage 8: cross magnitudes, obtuse flags and the zero-area test.
  // --------------------------------------------------------------------------
  logic signed [SPW-1:0] sp_q [NP];
  logic signed [XW-1:0]  cr_q [3];
  logic signed [DW-1:0]  d_q [3];
  logic [QW-1:0]         sq_q [3];
  logic [XMW-1:0]        xa_q [3];
  logic [QW-1:0]         dm_q [3];
  logic [QW-1:0]         sq8_q [3];
  logic [3:0]            fl8_q;       // degenerate, obtuse c, b, a

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int n = 0; n < NP; n++) begin
        sp_q[n] <= sgd_q[MUL_LAT-1][n] ? -SPW'(pm[n]) : SPW'(pm[n]);
      end
      fl8_q[3] <= (cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0);
      for (int i = 0; i < 3; i++) begin
        cr_q[i]  <= XW'(sp_q[2*i]) - XW'(sp_q[2*i+1]);
        d_q[i]   <= DW'(sp_q[DOT0+3*i]) + DW'(sp_q[DOT0+3*i+1]) + DW'(sp_q[DOT0+3*i+2]);
        sq_q[i]  <= QW'(sp_q[SQ0+3*i][SPW-2:0]) + QW'(sp_q[SQ0+3*i+1][SPW-2:0])
                  + QW'(sp_q[SQ0+3*i+2][SPW-2:0]);
        xa_q[i]  <= cr_q[i][XW-1] ? XMW'(-cr_q[i]) : XMW'(cr_q[i]);
        dm_q[i]  <= d_q[i][QW-1:0];
        fl8_q[i] <= d_q[i][DW-1];
        sq8_q[i] <= sq_q[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 9 to 11: cross squares and Voronoi numerator products.
  // Stage 12: squared norm and numerators.
  // --------------------------------------------------------------------------
  logic [2*XMW-1:0] xs [3];
  logic [2*QW-1:0]  nm [6];
  logic [3:0]       fld_q [MUL_LAT+1];
  logic [SW-1:0]    s_q;
  logic [NW-1:0]    n_q [3];

  for (genvar gi = 0; gi < 3; gi++) begin : g_nmul
    localparam int J = (gi + 1) % 3;
    localparam int M = (gi + 2) % 3;
    tmva_mul #(.W(XMW)) u_xsq (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (xa_q[gi]),
      .b_i   (xa_q[gi]),
      .p_o   (xs[gi])
    );
    tmva_mul #(.W(QW)) u_n0 (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (sq8_q[gi]),
      .b_i   (dm_q[M]),
      .p_o   (nm[2*gi])
    );
    tmva_mul #(.W(QW)) u_n1 (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (sq8_q[M]),
      .b_i   (dm_q[J]),
      .p_o   (nm[2*gi+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fld_q[0] <= fl8_q;
      for (int j = 1; j <= MUL_LAT; j++) begin
        fld_q[j] <= fld_q[j-1];
      end
      s_q <= SW'(xs[0]) + SW'(xs[1]) + SW'(xs[2]);
      for (int i = 0; i < 3; i++) begin
        n_q[i] <= NW'(nm[2*i]) + NW'(nm[2*i+1]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Square root, one root bit per stage, most significant bit first.
  // The remainder tracks S minus the square of the partial root.
  // --------------------------------------------------------------------------
  logic [SW-1:0] rt_rem_q  [TW];
  logic [TW-1:0] rt_root_q [TW];
  logic [NW-1:0] rt_n_q    [TW][3];
  logic [3:0]    rt_fl_q   [TW];

  for (genvar gs = 0; gs < TW; gs++) begin : g_sqrt
    localparam int BT = TW - 1 - gs;
    logic [SW-1:0] rem_in;
    logic [TW-1:0] root_in;
    logic [NW-1:0] n_in [3];
    logic [3:0]    fl_in;
    logic [SW+1:0] trial;
    logic          ge;
    if (gs == 0) begin : g_first
      assign rem_in  = s_q;
      assign root_in = '0;
      assign n_in    = n_q;
      assign fl_in   = fld_q[MUL_LAT];
    end else begin : g_next
      assign rem_in  = rt_rem_q[gs-1];
      assign root_in = rt_root_q[gs-1];
      assign n_in    = rt_n_q[gs-1];
      assign fl_in   = rt_fl_q[gs-1];
    end
    // The trial bit of the root sits below every bit already set, so the
    // increment of the square is an OR of both terms.
    assign trial = ((SW+2)'(root_in) << (BT + 1)) | ((SW+2)'(1) << (2 * BT));
    assign ge    = (SW+2)'(rem_in) >= trial;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rt_rem_q[gs]  <= ge ? rem_in - trial[SW-1:0] : rem_in;
        rt_root_q[gs] <= ge ? (root_in | (TW'(1) << BT)) : root_in;
        rt_n_q[gs]    <= n_in;
        rt_fl_q[gs]   <= fl_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Corner classification, fixed areas and the division overflow check.
  // --------------------------------------------------------------------------
  logic [RW-1:0]     t_ext;
  logic [RW-1:0]     qtr;
  logic [RW-1:0]     eig;
  logic [RW-1:0]     div_lim;
  logic              qsat;
  logic              esat;
  logic [3:0]        fl_t;
  logic [AREA_W-1:0] cl_fv [3];
  logic              cl_fs [3];
  logic              cl_uq [3];
  tmva_side_t        side_d;
  tmva_side_t        pr_side_q;
  logic [RW-1:0]     pr_r_q [3];
  logic [TW-1:0]     pr_t_q;

  assign t_ext   = RW'(rt_root_q[TW-1]);
  assign qtr     = t_ext >> QUARTER_SHIFT;
  assign eig     = t_ext >> EIGHTH_SHIFT;
  assign div_lim = t_ext << DIV_SAT_SHIFT;
  assign qsat    = |qtr[RW-1:AREA_W];
  assign esat    = |eig[RW-1:AREA_W];
  assign fl_t    = rt_fl_q[TW-1];

  for (genvar gi = 0; gi < 3; gi++) begin : g_class
    localparam int J = (gi + 1) % 3;
    localparam int M = (gi + 2) % 3;
    logic dsat;
    assign dsat = RW'(rt_n_q[TW-1][gi]) >= div_lim;
    always_comb begin
      if (fl_t[gi]) begin
        cl_fv[gi] = qsat ? '1 : qtr[AREA_W-1:0];
        cl_fs[gi] = qsat;
        cl_uq[gi] = 1'b0;
      end else if (fl_t[J] || fl_t[M]) begin
        cl_fv[gi] = esat ? '1 : eig[AREA_W-1:0];
        cl_fs[gi] = esat;
        cl_uq[gi] = 1'b0;
      end else begin
        cl_fv[gi] = '1;
        cl_fs[gi] = dsat;
        cl_uq[gi] = !dsat;
      end
    end
  end

  always_comb begin
    side_d.dg = fl_t[3];
    for (int i = 0; i < 3; i++) begin
      side_d.fv[i] = cl_fv[i];
      side_d.fs[i] = cl_fs[i];
      side_d.uq[i] = cl_uq[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_side_q <= side_d;
      pr_t_q    <= rt_root_q[TW-1];
      for (int i = 0; i < 3; i++) begin
        pr_r_q[i] <= RW'(rt_n_q[TW-1][i]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Restoring division of the numerators by T << 19, one quotient bit per
  // stage, for the three corners side by side.
  // --------------------------------------------------------------------------
  logic [RW-1:0]     dv_r_q    [AREA_W][3];
  logic [AREA_W-1:0] dv_q_q    [AREA_W][3];
  logic [TW-1:0]     dv_t_q    [AREA_W];
  tmva_side_t        dv_side_q [AREA_W];

  for (genvar gs = 0; gs < AREA_W; gs++) begin : g_div
    localparam int K = AREA_W - 1 - gs;
    logic [RW-1:0]     r_in [3];
    logic [AREA_W-1:0] q_in [3];
    logic [TW-1:0]     t_in;
    tmva_side_t        side_in;
    logic [RW-1:0]     dk;
    if (gs == 0) begin : g_first
      assign r_in    = pr_r_q;
      assign t_in    = pr_t_q;
      assign side_in = pr_side_q;
      for (genvar gi = 0; gi < 3; gi++) begin : g_q0
        assign q_in[gi] = '0;
      end
    end else begin : g_next
      assign r_in    = dv_r_q[gs-1];
      assign q_in    = dv_q_q[gs-1];
      assign t_in    = dv_t_q[gs-1];
      assign side_in = dv_side_q[gs-1];
    end
    assign dk = RW'(t_in) << (DIV_SHIFT + K);
    for (genvar gi = 0; gi < 3; gi++) begin : g_lane
      logic ge;
      assign ge = r_in[gi] >= dk;
      always_ff @(posedge clk_i) begin
        if (adv) begin
          dv_r_q[gs][gi] <= ge ? r_in[gi] - dk : r_in[gi];
          dv_q_q[gs][gi] <= q_in[gi] | (AREA_W'(ge) << K);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_t_q[gs]    <= t_in;
        dv_side_q[gs] <= side_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result selection, output register and skid register.
  // --------------------------------------------------------------------------
  tmva_side_t          fin_side;
  logic [3*AREA_W-1:0] fin_area;
  logic [1:0]          fin_user;

  assign fin_side = dv_side_q[AREA_W-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (fin_side.dg) begin
        fin_area[i*AREA_W +: AREA_W] = '0;
      end else if (fin_side.uq[i]) begin
        fin_area[i*AREA_W +: AREA_W] = dv_q_q[AREA_W-1][i];
      end else begin
        fin_area[i*AREA_W +: AREA_W] = fin_side.fv[i];
      end
    end
    fin_user = {!fin_side.dg && (|fin_side.fs), fin_side.dg};
  end

  logic                out_v_q, out_v_d;
  logic [3*AREA_W-1:0] out_area_q, out_area_d;
  logic [1:0]          out_user_q, out_user_d;
  logic                sk_v_q, sk_v_d;
  logic [3*AREA_W-1:0] sk_area_q, sk_area_d;
  logic [1:0]          sk_user_q, sk_user_d;

  assign adv  = !sk_v_q;
  assign push = adv && v_q[NST];
  assign take = out_v_q && m_axis_tready;

  always_comb begin
    out_v_d    = out_v_q;
    out_area_d = out_area_q;
    out_user_d = out_user_q;
    sk_v_d     = sk_v_q;
    sk_area_d  = sk_area_q;
    sk_user_d  = sk_user_q;
    if (sk_v_q) begin
      if (take) begin
        out_area_d = sk_area_q;
        out_user_d = sk_user_q;
        sk_v_d     = 1'b0;
      end
    end else if (push) begin
      if (!out_v_q || take) begin
        out_v_d    = 1'b1;
        out_area_d = fin_area;
        out_user_d = fin_user;
      end else begin
        sk_v_d    = 1'b1;
        sk_area_d = fin_area;
        sk_user_d = fin_user;
      end
    end else if (take) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else begin
      if (adv) begin
        v_q <= {v_q[NST-1:1], s_axis_tvalid};
      end
      out_v_q <= out_v_d;
      sk_v_q  <= sk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_area_q <= out_area_d;
    out_user_q <= out_user_d;
    sk_area_q  <= sk_area_d;
    sk_user_q  <= sk_user_d;
  end

  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_area_q;
  assign m_axis_tuser  = out_user_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`include "assert_macros.svh"

  `TMVA_ASSERT_NEVER(a_skid_without_out, sk_v_q && !out_v_q)
  `TMVA_ASSERT(a_stall_freezes_pipe, !adv |=> $stable(v_q))
  `TMVA_ASSERT(a_blocked_result_to_skid, (push && out_v_q && !m_axis_tready) |=> sk_v_q)
  `TMVA_ASSERT(a_degenerate_clean, (out_v_q && out_user_q[0]) |-> (!out_user_q[1] && out_area_q == '0))

endmodule

`default_nettype wire
